FILE: sv/ppi_pkg.sv
// Package for the mode 0 parallel port block: access codes, control word bit
// positions, read constants and the item structs shared by the modules.
// No dependencies.
`default_nettype none

package ppi_pkg;

   typedef enum logic {
      ACCESS_READ  = 1'b0,
      ACCESS_WRITE = 1'b1
   } ppi_access_type;

   typedef enum logic [1:0] {
      ADDR_PORT_A  = 2'd0,
      ADDR_PORT_B  = 2'd1,
      ADDR_PORT_C  = 2'd2,
      ADDR_CONTROL = 2'd3
   } ppi_addr_type;

   // Control word bit positions
   localparam int unsigned CTRL_MODE_SET    = 7;
   localparam int unsigned CTRL_GA_MODE_HI  = 6;
   localparam int unsigned CTRL_GA_MODE_LO  = 5;
   localparam int unsigned CTRL_DIR_A       = 4;
   localparam int unsigned CTRL_DIR_C_HIGH  = 3;
   localparam int unsigned CTRL_GB_MODE     = 2;
   localparam int unsigned CTRL_DIR_B       = 1;
   localparam int unsigned CTRL_DIR_C_LOW   = 0;

   localparam logic [7:0] CTRL_READ_FORCE  = 8'h80;
   localparam logic [7:0] PORT_INPUT_READ  = 8'hFF;
   localparam logic [7:0] BSR_BIT_ONE      = 8'h01;

   typedef struct packed {
      logic       mode;
      logic [1:0] address;
      logic [7:0] write_data;
      logic [7:0] port_b_pins;
   } ppi_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] port_a_level;
      logic       port_a_update;
      logic [3:0] keyboard_row;
      logic       sound_bit;
      logic       port_c_update;
   } ppi_rsp_type;

   // Port directions, 1 means input
   typedef struct packed {
      logic a_input;
      logic b_input;
      logic c_low_input;
      logic c_high_input;
   } ppi_dir_type;

endpackage

`default_nettype wire

FILE: sv/ppi_if.sv
// Valid/ready channel interfaces for the parallel port block: the access
// request channel and the result channel. No dependencies.
`default_nettype none

interface ppi_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [1:0] address;
   logic [7:0] write_data;
   logic [7:0] port_b_pins;

   modport source (output valid, mode, address, write_data, port_b_pins, input ready);
   modport sink   (input valid, mode, address, write_data, port_b_pins, output ready);
endinterface

interface ppi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [7:0] port_a_level;
   logic       port_a_update;
   logic [3:0] keyboard_row;
   logic       sound_bit;
   logic       port_c_update;

   modport source (output valid, read_data, port_a_level, port_a_update, keyboard_row,
                   sound_bit, port_c_update, input ready);
   modport sink   (input valid, read_data, port_a_level, port_a_update, keyboard_row,
                   sound_bit, port_c_update, output ready);
endinterface

`default_nettype wire

FILE: sv/parallel_port_interface_mode0_unit.sv
// Requests go through the request register into the result register, one
// access per cycle while rsp_chan.ready is high; the request register
// advances into the result register whenever the result is empty or being
// taken this cycle. Reset: synchronous, active high; clears port latches,
// control word and directions (all outputs); empties both pipeline registers.
// Top level of the mode 0 parallel port. Depends on ppi_pkg, ppi_if, ppi_core.
`default_nettype none

module parallel_port_interface_mode0_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   ppi_req_if.sink    req_chan,
   ppi_rsp_if.source  rsp_chan
);

   logic                 in_valid_ff;
   ppi_pkg::ppi_req_type in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   ppi_pkg::ppi_rsp_type out_item_ff;
   ppi_pkg::ppi_rsp_type result;
   logic                 advance;
   logic                 accept;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_valid_in   = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on accept / advance, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.mode        <= req_chan.mode;
         in_item_ff.address     <= req_chan.address;
         in_item_ff.write_data  <= req_chan.write_data;
         in_item_ff.port_b_pins <= req_chan.port_b_pins;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   ppi_core u_ppi_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (result)
   );

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.read_data     = out_item_ff.read_data;
   assign rsp_chan.port_a_level  = out_item_ff.port_a_level;
   assign rsp_chan.port_a_update = out_item_ff.port_a_update;
   assign rsp_chan.keyboard_row  = out_item_ff.keyboard_row;
   assign rsp_chan.sound_bit     = out_item_ff.sound_bit;
   assign rsp_chan.port_c_update = out_item_ff.port_c_update;

endmodule

`default_nettype wire

FILE: sv/ppi_core.sv
// Port latches, control word and direction state, with the access decode
// that turns one request item into one result item. Depends on ppi_pkg.
`default_nettype none

module ppi_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire ppi_pkg::ppi_req_type item,
   output ppi_pkg::ppi_rsp_type     result
);

   logic [7:0]           latch_a_ff, latch_a_in;
   logic [7:0]           latch_b_ff, latch_b_in;
   logic [7:0]           latch_c_ff, latch_c_in;
   logic [7:0]           control_ff, control_in;
   ppi_pkg::ppi_dir_type dir_ff, dir_in;

   ppi_pkg::ppi_addr_type addr;
   logic [7:0]            bit_mask;
   logic [7:0]            rd;
   logic                  a_upd;
   logic                  c_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_a_ff <= '0;
         latch_b_ff <= '0;
         latch_c_ff <= '0;
         control_ff <= '0;
         dir_ff     <= '0;
      end else if (advance) begin
         latch_a_ff <= latch_a_in;
         latch_b_ff <= latch_b_in;
         latch_c_ff <= latch_c_in;
         control_ff <= control_in;
         dir_ff     <= dir_in;
      end
   end

   always_comb begin
      addr       = ppi_pkg::ppi_addr_type'(item.address);
      bit_mask   = 8'd1 << item.write_data[3:1];
      latch_a_in = latch_a_ff;
      latch_b_in = latch_b_ff;
      latch_c_in = latch_c_ff;
      control_in = control_ff;
      dir_in     = dir_ff;
      rd         = '0;
      a_upd      = 1'b0;
      c_upd      = 1'b0;

      if (item.mode == ppi_pkg::ACCESS_WRITE) begin
         unique case (addr)
            ppi_pkg::ADDR_PORT_A: begin
               latch_a_in = item.write_data;
               a_upd      = !dir_ff.a_input;
            end
            ppi_pkg::ADDR_PORT_B: begin
               latch_b_in = item.write_data;
            end
            ppi_pkg::ADDR_PORT_C: begin
               latch_c_in = item.write_data;
               c_upd      = !(dir_ff.c_low_input && dir_ff.c_high_input);
            end
            ppi_pkg::ADDR_CONTROL: begin
               if (item.write_data[ppi_pkg::CTRL_MODE_SET]) begin
                  control_in = item.write_data;
                  // only mode 0 groups take new directions
                  if (!item.write_data[ppi_pkg::CTRL_GA_MODE_HI] &&
                      !item.write_data[ppi_pkg::CTRL_GA_MODE_LO]) begin
                     dir_in.a_input      = item.write_data[ppi_pkg::CTRL_DIR_A];
                     dir_in.c_high_input = item.write_data[ppi_pkg::CTRL_DIR_C_HIGH];
                  end
                  if (!item.write_data[ppi_pkg::CTRL_GB_MODE]) begin
                     dir_in.b_input     = item.write_data[ppi_pkg::CTRL_DIR_B];
                     dir_in.c_low_input = item.write_data[ppi_pkg::CTRL_DIR_C_LOW];
                  end
                  a_upd = 1'b1;
                  c_upd = 1'b1;
               end else begin
                  // bit set/reset on the port C latch
                  if ((item.write_data & ppi_pkg::BSR_BIT_ONE) != '0) begin
                     latch_c_in = latch_c_ff | bit_mask;
                  end else begin
                     latch_c_in = latch_c_ff & ~bit_mask;
                  end
                  c_upd = 1'b1;
               end
            end
         endcase
      end else begin
         unique case (addr)
            ppi_pkg::ADDR_PORT_A:  rd = dir_ff.a_input ? ppi_pkg::PORT_INPUT_READ : latch_a_ff;
            ppi_pkg::ADDR_PORT_B:  rd = dir_ff.b_input ? item.port_b_pins : latch_b_ff;
            ppi_pkg::ADDR_PORT_C:  rd = latch_c_ff;
            ppi_pkg::ADDR_CONTROL: rd = control_ff | ppi_pkg::CTRL_READ_FORCE;
         endcase
      end

      result.read_data     = rd;
      result.port_a_level  = latch_a_in;
      result.port_a_update = a_upd;
      result.keyboard_row  = latch_c_in[3:0];
      result.sound_bit     = latch_c_in[7];
      result.port_c_update = c_upd;
   end

endmodule

`default_nettype wire

FILE: sv/ppi_checker.sv
// Port-level checks for the mode 0 parallel port top level, bound to it.
// Depends on parallel_port_interface_mode0_unit and the ppi_if channels.
`default_nettype none

module ppi_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_data,
   input wire logic [7:0] rsp_port_a_level,
   input wire logic       rsp_port_a_update,
   input wire logic [3:0] rsp_keyboard_row,
   input wire logic       rsp_sound_bit,
   input wire logic       rsp_port_c_update
);

   // Pipeline is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A new result item must come from an accepted request that has passed through the request and result registers
   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a preceding accept");

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_read_data) && $stable(rsp_port_a_level) &&
         $stable(rsp_port_a_update) && $stable(rsp_keyboard_row) &&
         $stable(rsp_sound_bit) && $stable(rsp_port_c_update))
      else $error("result payload changed while stalled");

endmodule

bind parallel_port_interface_mode0_unit ppi_checker u_ppi_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_read_data     (rsp_chan.read_data),
   .rsp_port_a_level  (rsp_chan.port_a_level),
   .rsp_port_a_update (rsp_chan.port_a_update),
   .rsp_keyboard_row  (rsp_chan.keyboard_row),
   .rsp_sound_bit     (rsp_chan.sound_bit),
   .rsp_port_c_update (rsp_chan.port_c_update)
);

`default_nettype wire

FILE: bench/parallel_port_interface_mode0_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the mode 0 parallel port: directed accesses, then random ones,
// checked against the row's typed result or a local model of the port latches and directions.
// Depends on ppi_pkg, ppi_if and the parallel_port_interface_mode0_unit RTL.

module parallel_port_interface_mode0_unit_test;
   import ppi_pkg::*;

   typedef struct packed {
      ppi_req_type acc;
      logic        typed_result;
      ppi_rsp_type rsp;
   } access_row_type;

   localparam ppi_rsp_type FROM_MODEL = '0;
   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_COUNT = 575;

   // Rows with typed_result set carry their result; the rest go through the model.
   localparam access_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{'{ACCESS_READ,  ADDR_PORT_A,  8'hFF, 8'hFF}, 1'b1, '{8'h00, 8'h00, 1'b0, 4'h0, 1'b0, 1'b0}},
      '{'{ACCESS_READ,  ADDR_CONTROL, 8'h00, 8'h00}, 1'b1, '{8'h80, 8'h00, 1'b0, 4'h0, 1'b0, 1'b0}},
      '{'{ACCESS_WRITE, ADDR_PORT_A,  8'hFF, 8'h00}, 1'b1, '{8'h00, 8'hFF, 1'b1, 4'h0, 1'b0, 1'b0}},
      '{'{ACCESS_READ,  ADDR_PORT_A,  8'h00, 8'h00}, 1'b1, '{8'hFF, 8'hFF, 1'b0, 4'h0, 1'b0, 1'b0}},
      '{'{ACCESS_WRITE, ADDR_PORT_C,  8'h8F, 8'h00}, 1'b1, '{8'h00, 8'hFF, 1'b0, 4'hF, 1'b1, 1'b1}},
      '{'{ACCESS_WRITE, ADDR_PORT_B,  8'hA5, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_READ,  ADDR_PORT_B,  8'h00, 8'h3C}, 1'b0, FROM_MODEL},
      '{'{ACCESS_WRITE, ADDR_CONTROL, 8'h9B, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_READ,  ADDR_PORT_A,  8'h00, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_WRITE, ADDR_PORT_A,  8'h00, 8'hFF}, 1'b0, FROM_MODEL},
      '{'{ACCESS_READ,  ADDR_PORT_B,  8'h00, 8'h3C}, 1'b0, FROM_MODEL},
      '{'{ACCESS_WRITE, ADDR_PORT_C,  8'h00, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_READ,  ADDR_PORT_C,  8'h00, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_READ,  ADDR_CONTROL, 8'h00, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_WRITE, ADDR_CONTROL, 8'h0F, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_WRITE, ADDR_CONTROL, 8'h00, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_WRITE, ADDR_CONTROL, 8'h01, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_WRITE, ADDR_CONTROL, 8'hE0, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_WRITE, ADDR_CONTROL, 8'hA4, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_WRITE, ADDR_PORT_C,  8'h55, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_READ,  ADDR_PORT_A,  8'h00, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_WRITE, ADDR_CONTROL, 8'h80, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_READ,  ADDR_PORT_B,  8'h00, 8'hFF}, 1'b0, FROM_MODEL},
      '{'{ACCESS_WRITE, ADDR_CONTROL, 8'h7E, 8'h00}, 1'b0, FROM_MODEL},
      '{'{ACCESS_READ,  ADDR_PORT_C,  8'hFF, 8'h00}, 1'b0, FROM_MODEL}
   };

   logic clock;
   logic reset;

   ppi_req_if req_chan ();
   ppi_rsp_if rsp_chan ();

   parallel_port_interface_mode0_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Model state, cleared once like the block at reset
   logic [7:0]  latch_a_model = '0;
   logic [7:0]  latch_b_model = '0;
   logic [7:0]  latch_c_model = '0;
   logic [7:0]  control_model = '0;
   ppi_dir_type dir_model = '0;

   ppi_rsp_type    predicted_results [$];
   access_row_type offered_accesses [$];
   int             mismatch_count = 0;
   int             accepted_count = 0;
   int             burst_left = 0;
   logic           long_hold_done = 1'b0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic ppi_rsp_type predict_access(input ppi_req_type acc);
      ppi_rsp_type r;
      logic [7:0]  bsr_mask;
      r = '0;
      if (acc.mode == ACCESS_WRITE) begin
         case (ppi_addr_type'(acc.address))
            ADDR_PORT_A: begin
               latch_a_model = acc.write_data;
               r.port_a_update = !dir_model.a_input;
            end
            ADDR_PORT_B: latch_b_model = acc.write_data;
            ADDR_PORT_C: begin
               latch_c_model = acc.write_data;
               r.port_c_update = !dir_model.c_low_input || !dir_model.c_high_input;
            end
            default: begin
               if (acc.write_data[CTRL_MODE_SET]) begin
                  control_model = acc.write_data;
                  // unsupported group modes keep that group's directions
                  if (!acc.write_data[CTRL_GA_MODE_HI] && !acc.write_data[CTRL_GA_MODE_LO]) begin
                     dir_model.a_input = acc.write_data[CTRL_DIR_A];
                     dir_model.c_high_input = acc.write_data[CTRL_DIR_C_HIGH];
                  end
                  if (!acc.write_data[CTRL_GB_MODE]) begin
                     dir_model.b_input = acc.write_data[CTRL_DIR_B];
                     dir_model.c_low_input = acc.write_data[CTRL_DIR_C_LOW];
                  end
                  r.port_a_update = 1'b1;
                  r.port_c_update = 1'b1;
               end else begin
                  bsr_mask = 8'h01 << acc.write_data[3:1];
                  if (acc.write_data[0])
                     latch_c_model = latch_c_model | bsr_mask;
                  else
                     latch_c_model = latch_c_model & ~bsr_mask;
                  r.port_c_update = 1'b1;
               end
            end
         endcase
      end else begin
         case (ppi_addr_type'(acc.address))
            ADDR_PORT_A: r.read_data = dir_model.a_input ? PORT_INPUT_READ : latch_a_model;
            ADDR_PORT_B: r.read_data = dir_model.b_input ? acc.port_b_pins : latch_b_model;
            ADDR_PORT_C: r.read_data = latch_c_model;
            default:     r.read_data = control_model | CTRL_READ_FORCE;
         endcase
      end
      r.port_a_level = latch_a_model;
      r.keyboard_row = latch_c_model[3:0];
      r.sound_bit = latch_c_model[7];
      return r;
   endfunction

   function automatic ppi_req_type random_access();
      ppi_req_type acc;
      acc.mode = ($urandom_range(0, 9) < 6) ? ACCESS_WRITE : ACCESS_READ;
      acc.address = 2'($urandom_range(0, 3));
      acc.write_data = 8'($urandom);
      acc.port_b_pins = 8'($urandom);
      // bias mode sets toward mode 0 groups so directions actually move
      if (acc.mode == ACCESS_WRITE && acc.address == ADDR_CONTROL
          && acc.write_data[CTRL_MODE_SET]) begin
         if ($urandom_range(0, 9) < 6) begin
            acc.write_data[CTRL_GA_MODE_HI] = 1'b0;
            acc.write_data[CTRL_GA_MODE_LO] = 1'b0;
         end
         if ($urandom_range(0, 9) < 6)
            acc.write_data[CTRL_GB_MODE] = 1'b0;
      end
      return acc;
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned seen);
      if (want != seen)
         note_failure($sformatf("%s expected 0x%0h, got 0x%0h", field, want, seen));
   endtask

   task automatic offer_access(input access_row_type row);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         req_chan.mode <= 1'($urandom);
         req_chan.address <= 2'($urandom);
         req_chan.write_data <= 8'($urandom);
         req_chan.port_b_pins <= 8'($urandom);
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      offered_accesses.push_back(row);
      req_chan.valid <= 1'b1;
      req_chan.mode <= row.acc.mode;
      req_chan.address <= row.acc.address;
      req_chan.write_data <= row.acc.write_data;
      req_chan.port_b_pins <= row.acc.port_b_pins;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   // Check results first, then log the accepted access, all on pre-edge values.
   always @(posedge clock) begin
      ppi_rsp_type    seen_rsp;
      ppi_rsp_type    want_rsp;
      ppi_req_type    acc;
      access_row_type row;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_rsp = '{rsp_chan.read_data, rsp_chan.port_a_level, rsp_chan.port_a_update,
                         rsp_chan.keyboard_row, rsp_chan.sound_bit, rsp_chan.port_c_update};
            if (predicted_results.size() == 0) begin
               note_failure($sformatf("result item with none awaited: 0x%0h", seen_rsp));
            end else begin
               want_rsp = predicted_results.pop_front();
               check_field("read_data", want_rsp.read_data, seen_rsp.read_data);
               check_field("port_a_level", want_rsp.port_a_level, seen_rsp.port_a_level);
               check_field("port_a_update", want_rsp.port_a_update, seen_rsp.port_a_update);
               check_field("keyboard_row", want_rsp.keyboard_row, seen_rsp.keyboard_row);
               check_field("sound_bit", want_rsp.sound_bit, seen_rsp.sound_bit);
               check_field("port_c_update", want_rsp.port_c_update, seen_rsp.port_c_update);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            acc = '{req_chan.mode, req_chan.address, req_chan.write_data,
                    req_chan.port_b_pins};
            row = offered_accesses.pop_front();
            want_rsp = predict_access(acc);
            predicted_results.push_back(row.typed_result ? row.rsp : want_rsp);
            accepted_count++;
         end
      end
   end

   // Result side: a rotating stall pattern, plus one long hold-off to fill the block.
   initial begin
      logic [15:0] stall_pattern;
      int          pattern_age;
      pattern_age = 0;
      stall_pattern = '1;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (!long_hold_done && accepted_count >= 200) begin
            rsp_chan.ready <= 1'b0;
            long_hold_done = 1'b1;
            repeat (300) @(posedge clock);
         end else begin
            if (pattern_age == 0) begin
               stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
               pattern_age = 64;
            end
            pattern_age--;
            rsp_chan.ready <= stall_pattern[pattern_age % 16];
            @(posedge clock);
         end
      end
   end

   initial begin
      access_row_type row;
      int             drain_cycles;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode = ACCESS_READ;
      req_chan.address = ADDR_PORT_A;
      req_chan.write_data = '0;
      req_chan.port_b_pins = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++)
         offer_access(DIRECTED_ROWS[i]);
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         row.acc = random_access();
         row.typed_result = 1'b0;
         row.rsp = FROM_MODEL;
         offer_access(row);
      end
      req_chan.valid <= 1'b0;

      drain_cycles = 0;
      while (predicted_results.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      if (predicted_results.size() != 0)
         note_failure($sformatf("%0d result items never arrived", predicted_results.size()));

      if (mismatch_count == 0)
         $display("parallel_port_interface_mode0_unit_test: PASS");
      else
         $display("parallel_port_interface_mode0_unit_test: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("parallel_port_interface_mode0_unit_test: FAIL");
      $finish;
   end

endmodule
